/* rtl/lhp_pkg.sv */
// Shared types, constants and the bucket limit table of the latency histogram.
`timescale 1ns / 1ps
`default_nettype none

package lhp_pkg;

    // Field widths of the channel payloads.
    localparam int DUR_FIELD_W   = 48;
    localparam int COUNT_FIELD_W = 32;
    localparam int BUCKET_W      = 4;
    localparam int LIMIT_W       = 24;
    localparam int NUM_PCT       = 4;

    // Eight limited buckets live in the cell row; the top bucket is open ended.
    localparam int NUM_CELLS = 8;
    localparam int CELL_SEL_W = 3;

    localparam logic [BUCKET_W-1:0] BUCKET_TOP = 4'd8;
    localparam logic [BUCKET_W-1:0] IDX_NONE   = 4'd8;

    localparam logic [LIMIT_W-1:0] LIMIT_TOP = 24'd10_000_000;

    // Rank scale factors: p50 compares n against 2*run, p95 and p99 against
    // 100*run, p999 against 1000*run.
    localparam int SCALE_P95  = 95;
    localparam int SCALE_P99  = 99;
    localparam int SCALE_P999 = 999;
    localparam int SCALE_100  = 100;
    localparam int SCALE_1000 = 1000;

    // Percentile slots inside a scan tag.
    localparam int PCT_50  = 0;
    localparam int PCT_95  = 1;
    localparam int PCT_99  = 2;
    localparam int PCT_999 = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control part of the scan wave that walks down the cell row.
    typedef struct packed {
        logic                               valid;
        logic [NUM_PCT-1:0][BUCKET_W-1:0]   pidx;
    } scan_tag_t;

    typedef struct packed {
        logic [DUR_FIELD_W-1:0] duration_ns;
    } in_item_t;

    typedef struct packed {
        logic [BUCKET_W-1:0]      bucket_index;
        logic [DUR_FIELD_W-1:0]   high_water_ns;
        logic [COUNT_FIELD_W-1:0] total_samples;
        logic [DUR_FIELD_W-1:0]   p50_ns;
        logic [DUR_FIELD_W-1:0]   p95_ns;
        logic [DUR_FIELD_W-1:0]   p99_ns;
        logic [DUR_FIELD_W-1:0]   p999_ns;
    } out_item_t;

    // Upper limit of each limited bucket, in nanoseconds.
    function automatic logic [LIMIT_W-1:0] limit_of(input logic [CELL_SEL_W-1:0] sel);
        logic [LIMIT_W-1:0] lim;
        unique case (sel)
            3'd0: lim = 24'd50_000;
            3'd1: lim = 24'd100_000;
            3'd2: lim = 24'd250_000;
            3'd3: lim = 24'd500_000;
            3'd4: lim = 24'd1_000_000;
            3'd5: lim = 24'd2_000_000;
            3'd6: lim = 24'd5_000_000;
            3'd7: lim = 24'd10_000_000;
            default: lim = LIMIT_TOP;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

/* rtl/lhp_stream_if.sv */
// Valid/ready stream interface that carries one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface lhp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/lhp_cell.sv */
// One histogram cell: a bucket counter with scaled copies and one scan stage.
`timescale 1ns / 1ps
`default_nettype none

module lhp_cell #(
    parameter int COUNT_WIDTH = 32,
    parameter int CELL_INDEX  = 0
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     inc,
    input  wire logic [COUNT_WIDTH-1:0]   n_x1,
    input  wire logic [COUNT_WIDTH+6:0]   n_x95,
    input  wire logic [COUNT_WIDTH+6:0]   n_x99,
    input  wire logic [COUNT_WIDTH+9:0]   n_x999,
    input  wire logic [COUNT_WIDTH+2:0]   run_in,
    input  wire logic [COUNT_WIDTH+9:0]   run100_in,
    input  wire logic [COUNT_WIDTH+12:0]  run1000_in,
    input  wire lhp_pkg::scan_tag_t       tag_in,
    output logic      [COUNT_WIDTH+2:0]   run_out,
    output logic      [COUNT_WIDTH+9:0]   run100_out,
    output logic      [COUNT_WIDTH+12:0]  run1000_out,
    output lhp_pkg::scan_tag_t            tag_out
);
    import lhp_pkg::*;

    localparam int RUN_W   = COUNT_WIDTH + 3;
    localparam int R100_W  = COUNT_WIDTH + 10;
    localparam int R1000_W = COUNT_WIDTH + 13;
    localparam int C100_W  = COUNT_WIDTH + 7;
    localparam int C1000_W = COUNT_WIDTH + 10;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [C100_W-1:0]      c100_reg;
    logic [C1000_W-1:0]     c1000_reg;

    logic [RUN_W-1:0]       run_next;
    logic [R100_W-1:0]      run100_next;
    logic [R1000_W-1:0]     run1000_next;
    scan_tag_t              tag_next;
    logic [NUM_PCT-1:0]     reached;

    logic [RUN_W-1:0]       run_reg;
    logic [R100_W-1:0]      run100_reg;
    logic [R1000_W-1:0]     run1000_reg;
    scan_tag_t              tag_reg;

    // The counter and its 100x and 1000x copies step together and stop together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            c100_reg  <= '0;
            c1000_reg <= '0;
        end
        else if (inc && (count_reg != '1))
        begin
            count_reg <= count_reg + COUNT_WIDTH'(1);
            c100_reg  <= c100_reg + C100_W'(SCALE_100);
            c1000_reg <= c1000_reg + C1000_W'(SCALE_1000);
        end
    end

    always_comb
    begin
        run_next     = run_in + RUN_W'(count_reg);
        run100_next  = run100_in + R100_W'(c100_reg);
        run1000_next = run1000_in + R1000_W'(c1000_reg);

        reached[PCT_50]  = (RUN_W + 1)'(n_x1) <= {run_next, 1'b0};
        reached[PCT_95]  = R100_W'(n_x95) <= run100_next;
        reached[PCT_99]  = R100_W'(n_x99) <= run100_next;
        reached[PCT_999] = R1000_W'(n_x999) <= run1000_next;

        tag_next.valid = tag_in.valid;
        for (int k = 0; k < NUM_PCT; k++)
        begin
            if ((tag_in.pidx[k] == IDX_NONE) && reached[k])
                tag_next.pidx[k] = BUCKET_W'(CELL_INDEX);
            else
                tag_next.pidx[k] = tag_in.pidx[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_next;
    end

    always_ff @(posedge clk)
    begin
        run_reg     <= run_next;
        run100_reg  <= run100_next;
        run1000_reg <= run1000_next;
    end

    assign run_out     = run_reg;
    assign run100_out  = run100_reg;
    assign run1000_out = run1000_reg;
    assign tag_out     = tag_reg;

endmodule

`default_nettype wire

/* rtl/latency_histogram_percentiles.sv */
// Top level of the latency histogram with percentile estimates.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                          Transaction
// samples   in         duration_ns                      valid && ready
// results   out        bucket_index, high_water_ns,     valid && ready
//                      total_samples, p50/p95/p99/p999
//
// Each sample is binned on its transaction; then the sample count is scaled, the
// scan walks the row of eight bucket cells (one cell a cycle), the settled buckets
// are captured at the end of the row, and the result is built. A new sample is
// taken only when idle. Reset clears all counters and the high-water mark at once;
// no sweep follows. A stalled result waits in the output register while the next
// sample is binned.

module latency_histogram_percentiles #(
    parameter int COUNT_WIDTH    = 32,
    parameter int DURATION_WIDTH = 48
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lhp_stream_if.sink    samples,
    lhp_stream_if.source  results
);
    import lhp_pkg::*;

    localparam int RUN_W   = COUNT_WIDTH + 3;
    localparam int R100_W  = COUNT_WIDTH + 10;
    localparam int R1000_W = COUNT_WIDTH + 13;
    localparam int N95_W   = COUNT_WIDTH + 7;
    localparam int N999_W  = COUNT_WIDTH + 10;

    state_t state_reg;
    state_t state_next;

    // Handshake and sequencing strobes.
    logic in_acc;
    logic out_free;
    logic load_n;
    logic capture;
    logic load_out;

    // Histogram state kept outside the cells.
    logic [DURATION_WIDTH-1:0] peak_reg;
    logic [COUNT_WIDTH-1:0]    total_reg;
    logic [BUCKET_W-1:0]       bidx_reg;

    // Sample binning.
    logic [63:0]               dur_ext;
    logic [DURATION_WIDTH-1:0] dur;
    logic [NUM_CELLS-1:0]      below;
    logic [BUCKET_W-1:0]       bucket_sel;
    logic [NUM_CELLS-1:0]      inc_vec;

    // Scaled sample count, fixed while a scan runs.
    logic [COUNT_WIDTH-1:0] n1_reg;
    logic [N95_W-1:0]       n95_reg;
    logic [N95_W-1:0]       n99_reg;
    logic [N999_W-1:0]      n999_reg;
    logic                   start_reg;

    // Scan wave through the cell row.
    logic [RUN_W-1:0]   run_ch     [0:NUM_CELLS];
    logic [R100_W-1:0]  run100_ch  [0:NUM_CELLS];
    logic [R1000_W-1:0] run1000_ch [0:NUM_CELLS];
    scan_tag_t          tag_ch     [0:NUM_CELLS];

    logic [NUM_PCT-1:0][BUCKET_W-1:0] pidx_reg;

    // Result assembly.
    logic [DURATION_WIDTH-1:0]          peak_top;
    logic [63:0]                        top_ext;
    logic [63:0]                        peak_ext;
    logic [63:0]                        total_ext;
    logic [NUM_PCT-1:0][DUR_FIELD_W-1:0] est;

    out_item_t out_reg;
    logic      out_valid_reg;

    assign in_acc   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_PREP;
            end
            ST_PREP:
                state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (tag_ch[NUM_CELLS].valid)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        samples.ready = 1'b0;
        load_n        = 1'b0;
        capture       = 1'b0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: samples.ready = 1'b1;
            ST_PREP: load_n = 1'b1;
            ST_SCAN: capture = tag_ch[NUM_CELLS].valid;
            ST_DONE: load_out = out_free;
            default: samples.ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Binning. The sample is reduced to DURATION_WIDTH bits, compared with
    // all eight limits at once, and the first limit it stays under wins.
    // ------------------------------------------------------------------
    assign dur_ext = 64'(samples.payload.duration_ns);
    assign dur     = dur_ext[DURATION_WIDTH-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
            below[i] = dur < DURATION_WIDTH'(limit_of(CELL_SEL_W'(i)));
    end

    always_comb
    begin
        bucket_sel = BUCKET_TOP;
        for (int i = NUM_CELLS - 1; i >= 0; i--)
        begin
            if (below[i])
                bucket_sel = BUCKET_W'(i);
        end
    end

    // The top bucket has no cell: no estimate ever reads its count.
    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
            inc_vec[i] = in_acc && (bucket_sel == BUCKET_W'(i));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg  <= '0;
            total_reg <= '0;
        end
        else if (in_acc)
        begin
            if (dur > peak_reg)
                peak_reg <= dur;
            if (total_reg != '1)
                total_reg <= total_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            bidx_reg <= bucket_sel;
    end

    // ------------------------------------------------------------------
    // Rank scaling. Instead of dividing for ceil(p*n), each cell checks
    // p*n <= run scaled by the same denominator, which is exact for integers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_n)
        begin
            n1_reg   <= total_reg;
            n95_reg  <= N95_W'(total_reg) * N95_W'(SCALE_P95);
            n99_reg  <= N95_W'(total_reg) * N95_W'(SCALE_P99);
            n999_reg <= N999_W'(total_reg) * N999_W'(SCALE_P999);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= 1'b0;
        else
            start_reg <= load_n;
    end

    // ------------------------------------------------------------------
    // Cell row. The wave enters cell zero with empty running totals and no
    // percentile settled, and each cell adds its count and marks the ranks
    // it reaches first.
    // ------------------------------------------------------------------
    assign run_ch[0]     = '0;
    assign run100_ch[0]  = '0;
    assign run1000_ch[0] = '0;
    assign tag_ch[0]     = {start_reg, {NUM_PCT{IDX_NONE}}};

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        lhp_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .inc         (inc_vec[g]),
            .n_x1        (n1_reg),
            .n_x95       (n95_reg),
            .n_x99       (n99_reg),
            .n_x999      (n999_reg),
            .run_in      (run_ch[g]),
            .run100_in   (run100_ch[g]),
            .run1000_in  (run1000_ch[g]),
            .tag_in      (tag_ch[g]),
            .run_out     (run_ch[g+1]),
            .run100_out  (run100_ch[g+1]),
            .run1000_out (run1000_ch[g+1]),
            .tag_out     (tag_ch[g+1])
        );
    end

    // The last cell's tag holds the settling bucket of each percentile.
    always_ff @(posedge clk)
    begin
        if (capture)
            pidx_reg <= tag_ch[NUM_CELLS].pidx;
    end

    // ------------------------------------------------------------------
    // Result assembly. A rank past the last limit reports the larger of the
    // top limit and the high-water mark.
    // ------------------------------------------------------------------
    assign peak_top  = (peak_reg > DURATION_WIDTH'(LIMIT_TOP)) ?
                       peak_reg : DURATION_WIDTH'(LIMIT_TOP);
    assign top_ext   = 64'(peak_top);
    assign peak_ext  = 64'(peak_reg);
    assign total_ext = 64'(total_reg);

    always_comb
    begin
        for (int k = 0; k < NUM_PCT; k++)
        begin
            if (pidx_reg[k] == IDX_NONE)
                est[k] = top_ext[DUR_FIELD_W-1:0];
            else
                est[k] = DUR_FIELD_W'(limit_of(pidx_reg[k][CELL_SEL_W-1:0]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.bucket_index  <= bidx_reg;
            out_reg.high_water_ns <= peak_ext[DUR_FIELD_W-1:0];
            out_reg.total_samples <= total_ext[COUNT_FIELD_W-1:0];
            out_reg.p50_ns        <= est[PCT_50];
            out_reg.p95_ns        <= est[PCT_95];
            out_reg.p99_ns        <= est[PCT_99];
            out_reg.p999_ns       <= est[PCT_999];
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

endmodule

`default_nettype wire
